/* hw/rtl/kdhe_pkg.sv */
// Shared types and constants for the keypad debounce and hold event block.
`timescale 1ns / 1ps

package kdhe_pkg;

    // Number of active keys (1 to 8) and number of level fields on the port
    localparam int NUM_KEYS     = 8;
    localparam int LEVEL_FIELDS = 8;

    localparam int TIME_W  = 32;
    localparam int MS_W    = 16;
    localparam int LEVEL_W = 10;
    localparam int EVENT_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

    // Configuration reset values
    localparam logic [MS_W-1:0]    DEBOUNCE_RST  = 16'd50;
    localparam logic [MS_W-1:0]    HOLD_RST      = 16'd1000;
    localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 10'd512;

    // Item opcodes
    localparam logic OP_SCAN  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Event code for no event
    localparam logic [EVENT_W-1:0] EVENT_NONE = '0;

    // Per-key state machine
    typedef enum logic [2:0] {
        KEY_UP   = 3'b001,
        KEY_DOWN = 3'b010,
        KEY_HOLD = 3'b100
    } key_state_t;

    // What one key lane reports to the merge stage for the current item
    typedef struct packed {
        logic active;   // key is not UP after this item
        logic held;     // key is HOLD after this item
        logic pressed;  // key was sampled and reads pressed
    } lane_status_t;

endpackage : kdhe_pkg

/* hw/rtl/kdhe_lane.sv */
// One key lane: debounce window, UP/DOWN/HOLD state and toggle time stamp.
`timescale 1ns / 1ps

module kdhe_lane
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic                          clear,
    input  logic [kdhe_pkg::TIME_W-1:0]   now_ms,
    input  logic [kdhe_pkg::LEVEL_W-1:0]  level,
    input  logic [kdhe_pkg::MS_W-1:0]     debounce_ms,
    input  logic [kdhe_pkg::MS_W-1:0]     hold_ms,
    input  logic [kdhe_pkg::LEVEL_W-1:0]  press_threshold,
    output kdhe_pkg::lane_status_t        status
);
    import kdhe_pkg::*;

    key_state_t          state_reg;
    key_state_t          state_next;
    logic [TIME_W-1:0]   toggle_reg;
    logic [TIME_W-1:0]   toggle_next;
    logic [TIME_W-1:0]   diff;
    logic                sampled;
    logic                pressed;
    logic                was_pressed;
    logic                past_hold;

    // Elapsed time since last toggle, modulo 2^32
    assign diff        = now_ms - toggle_reg;
    assign sampled     = diff > {{(TIME_W-MS_W){1'b0}}, debounce_ms};
    assign past_hold   = diff > {{(TIME_W-MS_W){1'b0}}, hold_ms};
    assign pressed     = level < press_threshold;
    assign was_pressed = (state_reg != KEY_UP);

    // Advance the key machine for a scan item
    always_comb
    begin
        state_next  = state_reg;
        toggle_next = toggle_reg;
        if (sampled)
        begin
            unique case (state_reg)
                KEY_UP:
                begin
                    if (pressed)
                    begin
                        state_next  = KEY_DOWN;
                        toggle_next = now_ms;
                    end
                end
                KEY_DOWN, KEY_HOLD:
                begin
                    if (!pressed)
                    begin
                        state_next  = KEY_UP;
                        toggle_next = now_ms;
                    end
                    else if (past_hold)
                    begin
                        state_next = KEY_HOLD;
                    end
                end
                default:
                begin
                    state_next = KEY_UP;
                end
            endcase
        end
    end

    // Report the post-update state to the merge stage
    assign status.active  = (state_next != KEY_UP);
    assign status.held    = (state_next == KEY_HOLD);
    assign status.pressed = sampled && pressed && (was_pressed || !was_pressed);

    // Commit state on an accepted item; clear releases and restamps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= KEY_UP;
            toggle_reg <= '0;
        end
        else if (fire)
        begin
            if (clear)
            begin
                state_reg  <= KEY_UP;
                toggle_reg <= now_ms;
            end
            else
            begin
                state_reg  <= state_next;
                toggle_reg <= toggle_next;
            end
        end
    end

endmodule : kdhe_lane

/* hw/rtl/kdhe_merge.sv */
// Merge stage: priority encoder, event latch, buzzer and output register.
`timescale 1ns / 1ps

module kdhe_merge
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic                           clear,
    input  kdhe_pkg::lane_status_t         status [kdhe_pkg::NUM_KEYS],
    input  logic                           out_ready,
    output logic                           in_ready,
    output logic                           out_valid,
    output logic [kdhe_pkg::EVENT_W-1:0]   event_code,
    output logic                           buzzer_on
);
    import kdhe_pkg::*;

    logic [EVENT_W-1:0] code;
    logic               any_pressed;
    logic [EVENT_W-1:0] latch_reg;
    logic               valid_reg;
    logic [EVENT_W-1:0] code_reg;
    logic               buzzer_reg;

    // Pick the first key that is not UP; key 0 wins
    always_comb
    begin
        code        = EVENT_NONE;
        any_pressed = 1'b0;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            if (status[k].active)
            begin
                code = EVENT_W'(2 * k + 1) + EVENT_W'(status[k].held);
            end
            if (status[k].pressed)
            begin
                any_pressed = 1'b1;
            end
        end
    end

    // Take a new item whenever the output register is empty or draining
    assign in_ready = !valid_reg || out_ready;

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            latch_reg <= EVENT_NONE;
        end
        else
        begin
            if (fire)
            begin
                valid_reg <= 1'b1;
                if (!clear)
                begin
                    latch_reg <= code;
                end
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: report a code only when it differs from the latch; a clear reports none
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (clear)
            begin
                code_reg   <= EVENT_NONE;
                buzzer_reg <= 1'b0;
            end
            else
            begin
                code_reg   <= (code != latch_reg) ? code : EVENT_NONE;
                buzzer_reg <= any_pressed;
            end
        end
    end

    assign out_valid  = valid_reg;
    assign event_code = code_reg;
    assign buzzer_on  = buzzer_reg;

endmodule : kdhe_merge

/* hw/rtl/keypad_debounce_hold_events_core.sv */
// Top level of the keypad debounce and hold event block.
`timescale 1ns / 1ps

// Each accepted item is either a scan (opcode 0) or a clear (opcode 1) and
// gives exactly one result: an event code (0 none, 1+2k key k down, 2+2k key
// k held) and a buzzer flag. All keys are updated in parallel lanes in the
// cycle the item is accepted, and the result is registered at that edge, so
// the block takes one item per clock cycle; it stalls only while a finished
// result waits for out_ready. Configuration writes (debounce_ms, hold_ms,
// press_threshold) take effect on the next item.
module keypad_debounce_hold_events_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [kdhe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kdhe_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic [kdhe_pkg::TIME_W-1:0]       now_ms,
    input  logic [kdhe_pkg::LEVEL_W-1:0]      level_0,
    input  logic [kdhe_pkg::LEVEL_W-1:0]      level_1,
    input  logic [kdhe_pkg::LEVEL_W-1:0]      level_2,
    input  logic [kdhe_pkg::LEVEL_W-1:0]      level_3,
    input  logic [kdhe_pkg::LEVEL_W-1:0]      level_4,
    input  logic [kdhe_pkg::LEVEL_W-1:0]      level_5,
    input  logic [kdhe_pkg::LEVEL_W-1:0]      level_6,
    input  logic [kdhe_pkg::LEVEL_W-1:0]      level_7,
    // result items
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [kdhe_pkg::EVENT_W-1:0]      event_code,
    output logic                              buzzer_on
);
    import kdhe_pkg::*;

    logic [MS_W-1:0]    debounce_reg;
    logic [MS_W-1:0]    hold_reg;
    logic [LEVEL_W-1:0] threshold_reg;
    logic               fire;
    logic               clear;
    logic [LEVEL_W-1:0] level_arr [LEVEL_FIELDS];
    lane_status_t       status [NUM_KEYS];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RST;
            hold_reg      <= HOLD_RST;
            threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:  debounce_reg  <= cfg_data[MS_W-1:0];
                CFG_HOLD:      hold_reg      <= cfg_data[MS_W-1:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data[LEVEL_W-1:0];
                default:       ;
            endcase
        end
    end

    assign fire  = in_valid && in_ready;
    assign clear = (opcode == OP_CLEAR);

    // Gather level ports into lane order
    assign level_arr[0] = level_0;
    assign level_arr[1] = level_1;
    assign level_arr[2] = level_2;
    assign level_arr[3] = level_3;
    assign level_arr[4] = level_4;
    assign level_arr[5] = level_5;
    assign level_arr[6] = level_6;
    assign level_arr[7] = level_7;

    // One lane per active key
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        kdhe_lane u_lane
        (
            .clk             (clk),
            .rst_n           (rst_n),
            .fire            (fire),
            .clear           (clear),
            .now_ms          (now_ms),
            .level           (level_arr[k]),
            .debounce_ms     (debounce_reg),
            .hold_ms         (hold_reg),
            .press_threshold (threshold_reg),
            .status          (status[k])
        );
    end

    // Combine lane results into one event
    kdhe_merge u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .clear      (clear),
        .status     (status),
        .out_ready  (out_ready),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .event_code (event_code),
        .buzzer_on  (buzzer_on)
    );

endmodule : keypad_debounce_hold_events_core

/* tb/sv/keypad_debounce_hold_events_core_tb.sv */
// Self-checking testbench for the keypad debounce and hold event block.
`timescale 1ns / 1ps

module keypad_debounce_hold_events_core_tb;

    import kdhe_pkg::*;

    // Index with no register behind it; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic                                   opcode;
        logic [TIME_W-1:0]                      now_ms;
        logic [LEVEL_FIELDS-1:0][LEVEL_W-1:0]   level;
    } scan_item_t;

    typedef struct packed {
        logic [EVENT_W-1:0] code;
        logic               buzzer;
    } event_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [EVENT_W-1:0]     event_code;
    logic                   buzzer_on;
    scan_item_t             drive_item = '0;

    // Stimulus and scoreboard state
    scan_item_t             scan_items[$];
    event_result_t          expected_events[$];
    logic                   in_took = 1'b0;
    logic                   calm = 1'b0;
    int                     mismatch_count = 0;
    logic [TIME_W-1:0]      gen_clock_ms = '0;
    logic [NUM_KEYS-1:0]    finger_down = '0;

    // Predictor copy of the configuration and key state
    logic [MS_W-1:0]        debounce_cfg = DEBOUNCE_RST;
    logic [MS_W-1:0]        hold_cfg = HOLD_RST;
    logic [LEVEL_W-1:0]     threshold_cfg = THRESHOLD_RST;
    key_state_t             key_phase[NUM_KEYS];
    logic [TIME_W-1:0]      toggle_stamp[NUM_KEYS];
    logic [EVENT_W-1:0]     last_event = EVENT_NONE;

    keypad_debounce_hold_events_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (drive_item.opcode),
        .now_ms     (drive_item.now_ms),
        .level_0    (drive_item.level[0]),
        .level_1    (drive_item.level[1]),
        .level_2    (drive_item.level[2]),
        .level_3    (drive_item.level[3]),
        .level_4    (drive_item.level[4]),
        .level_5    (drive_item.level[5]),
        .level_6    (drive_item.level[6]),
        .level_7    (drive_item.level[7]),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_code (event_code),
        .buzzer_on  (buzzer_on)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("keypad_debounce_hold_events_core_tb: FAIL");
        $finish;
    end

    // Advance the key machines by one item and return the result it gives
    function automatic event_result_t predict_event(input scan_item_t it);
        event_result_t     r;
        logic [TIME_W-1:0] since;
        logic              pressed;
        logic [EVENT_W-1:0] code;
        r = '0;
        if (it.opcode == OP_CLEAR)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                key_phase[k] = KEY_UP;
                toggle_stamp[k] = it.now_ms;
            end
            return r;
        end
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            since = it.now_ms - toggle_stamp[k];
            if (since > TIME_W'(debounce_cfg))
            begin
                pressed = it.level[k] < threshold_cfg;
                if (pressed)
                    r.buzzer = 1'b1;
                if (pressed && key_phase[k] == KEY_UP)
                begin
                    key_phase[k] = KEY_DOWN;
                    toggle_stamp[k] = it.now_ms;
                end
                else if (!pressed && key_phase[k] != KEY_UP)
                begin
                    key_phase[k] = KEY_UP;
                    toggle_stamp[k] = it.now_ms;
                end
                else if (pressed && since > TIME_W'(hold_cfg))
                    key_phase[k] = KEY_HOLD;
            end
        end
        // Lowest key index that is not up wins
        code = EVENT_NONE;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            if (key_phase[k] == KEY_DOWN)
                code = EVENT_W'(1 + 2 * k);
            else if (key_phase[k] == KEY_HOLD)
                code = EVENT_W'(2 + 2 * k);
        end
        if (code != last_event)
        begin
            last_event = code;
            r.code = code;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Sample both channels, predict on input, check on output
    always @(posedge clk)
    begin : monitor
        event_result_t want;
        in_took = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_events.push_back(predict_event(drive_item));
                in_took = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                    report_mismatch("result item with no expectation pending");
                else
                begin
                    want = expected_events.pop_front();
                    if (event_code !== want.code)
                        report_mismatch($sformatf("event_code got %0d expected %0d",
                                                  event_code, want.code));
                    if (buzzer_on !== want.buzzer)
                        report_mismatch($sformatf("buzzer_on got %b expected %b",
                                                  buzzer_on, want.buzzer));
                end
            end
        end
    end

    // Hold the current item until taken, then offer the next one or idle
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_took)
        begin
            if (scan_items.size() != 0 && (calm || $urandom_range(99) >= 20))
            begin
                drive_item <= scan_items.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall the result side at random
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= 20);
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_DEBOUNCE:  debounce_cfg = data;
            CFG_HOLD:      hold_cfg = data;
            CFG_THRESHOLD: threshold_cfg = data[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every item is taken and every result has come back
    task automatic wait_drained();
        while (scan_items.size() != 0 || in_valid || expected_events.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Queue one item: keys in held_keys get low_lvl, the others high_lvl
    task automatic queue_directed(input logic op, input logic [TIME_W-1:0] at_ms,
                                  input logic [NUM_KEYS-1:0] held_keys,
                                  input logic [LEVEL_W-1:0] low_lvl,
                                  input logic [LEVEL_W-1:0] high_lvl);
        scan_item_t it;
        it.opcode = op;
        it.now_ms = at_ms;
        for (int k = 0; k < LEVEL_FIELDS; k++)
            it.level[k] = held_keys[k] ? low_lvl : high_lvl;
        scan_items.push_back(it);
    endtask

    // Queue press and release sequences with random timing and noise
    task automatic queue_random(input int count, input int unsigned max_step);
        scan_item_t it;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 3)
                gen_clock_ms = $urandom();
            else
                gen_clock_ms = gen_clock_ms + $urandom_range(max_step);
            it.opcode = ($urandom_range(99) < 3) ? OP_CLEAR : OP_SCAN;
            it.now_ms = gen_clock_ms;
            for (int k = 0; k < LEVEL_FIELDS; k++)
            begin
                if ($urandom_range(7) == 0)
                    finger_down[k] = ~finger_down[k];
                if ($urandom_range(9) == 0 || (finger_down[k] && threshold_cfg == 0))
                    it.level[k] = LEVEL_W'($urandom_range(1023));
                else if (finger_down[k])
                    it.level[k] = LEVEL_W'($urandom_range(threshold_cfg - 1, 0));
                else
                    it.level[k] = LEVEL_W'($urandom_range(1023, threshold_cfg));
            end
            scan_items.push_back(it);
        end
    endtask

    initial
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            key_phase[k] = KEY_UP;
            toggle_stamp[k] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: debounce and hold edges, priority, clear, wrap, repeats
        queue_directed(OP_SCAN,  32'd0,    8'h00, 10'd0,   10'd1023);
        queue_directed(OP_SCAN,  32'd50,   8'h01, 10'd0,   10'd1023);
        queue_directed(OP_SCAN,  32'd51,   8'h01, 10'd0,   10'd1023);
        queue_directed(OP_SCAN,  32'd60,   8'h00, 10'd0,   10'd1023);
        queue_directed(OP_SCAN,  32'd102,  8'h01, 10'd511, 10'd512);
        queue_directed(OP_SCAN,  32'd1051, 8'h01, 10'd511, 10'd512);
        queue_directed(OP_SCAN,  32'd1052, 8'h01, 10'd511, 10'd512);
        queue_directed(OP_SCAN,  32'd1100, 8'h81, 10'd0,   10'd1023);
        queue_directed(OP_SCAN,  32'd1200, 8'h80, 10'd0,   10'd1023);
        queue_directed(OP_SCAN,  32'd2300, 8'h80, 10'd0,   10'd1023);
        queue_directed(OP_CLEAR, 32'd2400, 8'hFF, 10'd0,   10'd0);
        queue_directed(OP_SCAN,  32'd2420, 8'hFF, 10'd0,   10'd1023);
        queue_directed(OP_SCAN,  32'd2451, 8'hFF, 10'd0,   10'd1023);
        queue_directed(OP_SCAN,  32'd2510, 8'hFE, 10'd0,   10'd1023);
        queue_directed(OP_SCAN,  32'd2600, 8'h00, 10'd0,   10'd1023);
        queue_directed(OP_SCAN,  32'hFFFF_FFF0, 8'h00, 10'd0, 10'd1023);
        queue_directed(OP_SCAN,  32'h0000_0030, 8'h08, 10'd0, 10'd1023);
        queue_directed(OP_SCAN,  32'h0000_0030, 8'h08, 10'd0, 10'd1023);
        queue_directed(OP_SCAN,  32'h0000_1000, 8'h55, 10'd0, 10'd1023);
        queue_directed(OP_SCAN,  32'hFFFF_FFFF, 8'hAA, 10'd0, 10'd1023);
        queue_directed(OP_CLEAR, 32'hAAAA_5555, 8'h0F, 10'd1023, 10'd0);
        queue_directed(OP_SCAN,  32'hAAAA_55A0, 8'hFF, 10'd511, 10'd1023);
        wait_drained();

        // Zero windows and the top threshold
        write_register(CFG_DEBOUNCE, 16'd0);
        write_register(CFG_HOLD, 16'd0);
        write_register(CFG_THRESHOLD, 16'd1023);
        gen_clock_ms = $urandom();
        queue_random(150, 5);
        wait_drained();

        // Widest windows, threshold zero written with stray upper bits
        write_register(CFG_DEBOUNCE, 16'hFFFF);
        write_register(CFG_HOLD, 16'hFFFF);
        write_register(CFG_THRESHOLD, 16'hFC00);
        queue_random(100, 40000);
        wait_drained();

        // Moderate setting across the time wrap, with no idling on either side
        write_register(CFG_SPARE, 16'($urandom()));
        write_register(CFG_DEBOUNCE, 16'd20);
        write_register(CFG_HOLD, 16'd300);
        write_register(CFG_THRESHOLD, 16'hF6BC);
        calm = 1'b1;
        gen_clock_ms = 32'hFFFF_F000;
        queue_random(300, 60);
        wait_drained();
        calm = 1'b0;

        // A few random settings
        for (int p = 0; p < 3; p++)
        begin
            write_register(CFG_DEBOUNCE, 16'($urandom_range(300)));
            write_register(CFG_HOLD, 16'($urandom_range(3000)));
            write_register(CFG_THRESHOLD, 16'($urandom()));
            write_register(CFG_SPARE, 16'($urandom()));
            queue_random(110, 200);
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("keypad_debounce_hold_events_core_tb: PASS");
        else
            $display("keypad_debounce_hold_events_core_tb: FAIL");
        $finish;
    end

endmodule
